// ===== rtl/programmer_calculator_alu_assert.svh =====
// Assertion macros for the programmer calculator ALU.
// Included by the top level; the bodies are empty when SYNTH is defined.
`ifndef PROGRAMMER_CALCULATOR_ALU_ASSERT_SVH
`define PROGRAMMER_CALCULATOR_ALU_ASSERT_SVH
`ifndef SYNTH
`define PCALU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define PCALU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PCALU_ASSERT(label, prop, msg)
`define PCALU_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/pcalu_pkg.sv =====
// Package for the programmer calculator ALU: operation codes, register
// indexes, pipeline stage type and width helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pcalu_pkg;

   localparam int DIV_STEPS = 32;

   typedef enum logic [3:0] {
      OP_PASS = 4'd0,
      OP_AND  = 4'd1,
      OP_OR   = 4'd2,
      OP_XOR  = 4'd3,
      OP_NOT  = 4'd4,
      OP_SHL  = 4'd5,
      OP_SHR  = 4'd6,
      OP_ROTL = 4'd7,
      OP_ROTR = 4'd8,
      OP_MOD  = 4'd9,
      OP_DIV  = 4'd10,
      OP_MUL  = 4'd11,
      OP_SUB  = 4'd12,
      OP_ADD  = 4'd13
   } op_type;

   typedef enum logic [1:0] {
      WS_8  = 2'd0,
      WS_16 = 2'd1,
      WS_32 = 2'd2
   } wsel_type;

   localparam logic REG_WORD_SIZE   = 1'b0;
   localparam logic REG_SIGNED_MODE = 1'b1;

   // One stage of the divide pipeline; non-divide results ride along in res.
   typedef struct packed {
      logic [3:0]  op;
      logic [1:0]  wsel;
      logic        sgn;
      logic [63:0] res;
      logic        ovf;
      logic        derr;
      logic [31:0] rem;
      logic [31:0] quo;
      logic [31:0] dvs;
      logic        qneg;
      logic        rneg;
   } stage_type;

   function automatic logic [31:0] width_mask(input logic [1:0] wsel);
      unique case (wsel)
         WS_8:    width_mask = 32'h0000_00FF;
         WS_16:   width_mask = 32'h0000_FFFF;
         default: width_mask = 32'hFFFF_FFFF;
      endcase
   endfunction

   // Sign-extend the low word-size bits to 32 bits.
   function automatic logic [31:0] sext_w(input logic [31:0] x, input logic [1:0] wsel);
      unique case (wsel)
         WS_8:    sext_w = {{24{x[7]}}, x[7:0]};
         WS_16:   sext_w = {{16{x[15]}}, x[15:0]};
         default: sext_w = x;
      endcase
   endfunction

   function automatic logic sign_bit(input logic [31:0] x, input logic [1:0] wsel);
      unique case (wsel)
         WS_8:    sign_bit = x[7];
         WS_16:   sign_bit = x[15];
         default: sign_bit = x[31];
      endcase
   endfunction

endpackage
`default_nettype wire

// ===== rtl/programmer_calculator_alu.sv =====
// Programmer calculator ALU top level: input register, operand stage,
// 32-step divide pipeline and output register. Uses pcalu_pkg.
// One word enters every cycle; the 32 restoring-divide steps, one quotient
// bit per register stage, set the depth, and all other operations ride along
// with the divide data. The whole pipeline advances when the output register
// is empty or being taken, so a stall at rsp holds every stage in place.
// csr writes are taken at once and should only be made while no word is in
// flight; the word size and signed mode are sampled as a word enters.
`timescale 1ns / 1ps
`default_nettype none
`include "programmer_calculator_alu_assert.svh"
module programmer_calculator_alu (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // [31:0] operand_a, [63:32] operand_b
   input  wire logic [3:0]  req_tuser,  // [3:0] operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // [31:0] result_value, [32] carry_flag,
                                        // [33] overflow_flag, [34] divide_error
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [1:0]  csr_data
);
   import pcalu_pkg::*;

   logic [1:0]  wsel_ff;
   logic        sgn_ff;
   logic        advance;

   logic        in_vld_ff;
   logic [3:0]  in_op_ff;
   logic [31:0] in_a_ff, in_b_ff;
   logic [1:0]  in_wsel_ff;
   logic        in_sgn_ff;

   stage_type   pre_in;
   stage_type   pipe_ff [DIV_STEPS+1];
   logic        vld_ff  [DIV_STEPS+1];

   logic [39:0] rsp_in;
   logic [39:0] rsp_ff;
   logic        rsp_vld_ff;

   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wsel_ff <= WS_32;
         sgn_ff  <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_WORD_SIZE:   wsel_ff <= csr_data;
            REG_SIGNED_MODE: sgn_ff  <= csr_data[0];
            default:         ;
         endcase
      end
   end

   // Input register; word size 3 behaves as 32
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (advance) begin
         in_vld_ff <= req_tvalid;
      end
      if (advance) begin
         in_op_ff   <= req_tuser;
         in_a_ff    <= req_tdata[31:0];
         in_b_ff    <= req_tdata[63:32];
         in_wsel_ff <= (wsel_ff == 2'd3) ? 2'(WS_32) : wsel_ff;
         in_sgn_ff  <= sgn_ff;
      end
   end

   // Operand stage: all non-divide results, divide operand magnitudes
   always_comb begin
      logic [31:0] m, sa, sb, ma, mb;
      logic [63:0] v, a64, b64, diff, sum;
      logic [4:0]  r;
      logic [5:0]  wr;
      logic        na, nb;
      m    = width_mask(in_wsel_ff);
      sa   = sext_w(in_a_ff, in_wsel_ff);
      sb   = sext_w(in_b_ff, in_wsel_ff);
      ma   = sa[31] ? 32'(-sa) : sa;
      mb   = sb[31] ? 32'(-sb) : sb;
      a64  = {32'd0, in_a_ff};
      b64  = {32'd0, in_b_ff};
      diff = a64 - b64;
      sum  = a64 + b64;
      v    = {32'd0, in_a_ff & m};
      unique case (in_wsel_ff)
         WS_8:    begin r = {2'd0, in_b_ff[2:0]}; wr = 6'd8  - {1'b0, r}; end
         WS_16:   begin r = {1'b0, in_b_ff[3:0]}; wr = 6'd16 - {1'b0, r}; end
         default: begin r = in_b_ff[4:0];         wr = 6'd32 - {1'b0, r}; end
      endcase
      na = sign_bit(in_a_ff, in_wsel_ff);
      nb = sign_bit(in_b_ff, in_wsel_ff);

      pre_in      = '0;
      pre_in.op   = in_op_ff;
      pre_in.wsel = in_wsel_ff;
      pre_in.sgn  = in_sgn_ff;
      pre_in.qneg = sa[31] ^ sb[31];
      pre_in.rneg = sa[31];
      if (in_sgn_ff) begin
         pre_in.quo  = ma;
         pre_in.dvs  = mb;
         pre_in.derr = (sb == 32'd0);
      end else begin
         pre_in.quo  = in_a_ff;
         pre_in.dvs  = in_b_ff;
         pre_in.derr = (in_b_ff == 32'd0);
      end
      unique case (in_op_ff)
         OP_PASS: pre_in.res = a64;
         OP_AND:  pre_in.res = {32'd0, in_a_ff & in_b_ff};
         OP_OR:   pre_in.res = {32'd0, in_a_ff | in_b_ff};
         OP_XOR:  pre_in.res = {32'd0, in_a_ff ^ in_b_ff};
         OP_NOT:  pre_in.res = {32'd0, ~in_a_ff};
         OP_SHL:  pre_in.res = (in_b_ff > 32'd31) ? 64'd0
                               : {32'd0, (in_a_ff << in_b_ff[4:0]) & m};
         OP_SHR:  pre_in.res = (in_b_ff > 32'd31) ? 64'd0
                               : {32'd0, (in_a_ff >> in_b_ff[4:0]) & m};
         OP_ROTL: pre_in.res = ((v << r) | (v >> wr)) & {32'd0, m};
         OP_ROTR: pre_in.res = ((v >> r) | (v << wr)) & {32'd0, m};
         OP_MUL:  pre_in.res = a64 * b64;
         OP_SUB: begin
            pre_in.res = diff;
            pre_in.ovf = (!na && nb && sign_bit(diff[31:0], in_wsel_ff))
                      || (na && !nb && !sign_bit(diff[31:0], in_wsel_ff));
         end
         OP_ADD: begin
            pre_in.res = sum;
            pre_in.ovf = (na && nb && !sign_bit(sum[31:0], in_wsel_ff))
                      || (!na && !nb && sign_bit(sum[31:0], in_wsel_ff));
         end
         default: pre_in.res = 64'd0;
      endcase
      if (in_op_ff != OP_MOD && in_op_ff != OP_DIV) begin
         pre_in.derr = 1'b0;
      end
   end

   // Divide pipeline: one restoring step per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) vld_ff[k] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_vld_ff;
         for (int k = 0; k < DIV_STEPS; k++) vld_ff[k+1] <= vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff[0] <= pre_in;
         for (int k = 0; k < DIV_STEPS; k++) begin
            stage_type   nx;
            logic [32:0] t, d;
            t      = {pipe_ff[k].rem, pipe_ff[k].quo[31]};
            d      = t - {1'b0, pipe_ff[k].dvs};
            nx     = pipe_ff[k];
            nx.rem = d[32] ? t[31:0] : d[31:0];
            nx.quo = {pipe_ff[k].quo[30:0], ~d[32]};
            pipe_ff[k+1] <= nx;
         end
      end
   end

   // Output stage: divide sign fix and sign extension to word size, carry
   always_comb begin
      stage_type   s;
      logic [31:0] x, w32;
      logic [63:0] res;
      logic        neg, cy;
      s   = pipe_ff[DIV_STEPS];
      x   = (s.op == OP_MOD) ? s.rem : s.quo;
      neg = (s.op == OP_MOD) ? s.rneg : s.qneg;
      res = s.res;
      if (s.op == OP_MOD || s.op == OP_DIV) begin
         if (s.sgn) begin
            w32 = sext_w(neg ? 32'(-x) : x, s.wsel);
            res = {{32{w32[31]}}, w32};
         end else begin
            res = {32'd0, x};
         end
      end
      unique case (s.wsel)
         WS_8:    cy = |res[63:8];
         WS_16:   cy = |res[63:16];
         default: cy = |res[63:32];
      endcase
      if (s.derr) begin
         rsp_in = {5'd0, 1'b1, 2'b00, 32'd0};
      end else begin
         rsp_in = {5'd0, 1'b0, s.ovf, cy, res[31:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= vld_ff[DIV_STEPS];
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Checks
   `PCALU_ASSERT(a_derr_clean, rsp_vld_ff && rsp_ff[34] |-> rsp_ff[33:0] == 34'd0, "divide error word not clean")
   `PCALU_ASSERT(a_ovf_addsub, vld_ff[DIV_STEPS] && pipe_ff[DIV_STEPS].ovf |-> pipe_ff[DIV_STEPS].op == OP_ADD || pipe_ff[DIV_STEPS].op == OP_SUB, "overflow on non add/sub")
   `PCALU_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_vld_ff && !vld_ff[0], "pipeline not empty after reset")

endmodule
`default_nettype wire

// ===== test/tb_programmer_calculator_alu.sv =====
// Testbench for the programmer calculator ALU: directed table with typed results plus
// random words checked against a behavioral predictor. Depends on pcalu_pkg and the ALU top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_programmer_calculator_alu;
   import pcalu_pkg::*;

   localparam int LATENCY = 35;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [31:0] value;
      logic        carry;
      logic        ovf;
      logic        derr;
   } alu_out_t;

   typedef struct {
      logic [3:0]  op;
      logic [31:0] a;
      logic [31:0] b;
      logic        known;
      logic [31:0] value;
      logic        carry;
      logic        ovf;
      logic        derr;
   } vector_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [1:0]  csr_data = '0;

   // current settings mirrored for prediction
   logic [1:0]  cur_wsel = WS_32;
   logic        cur_sgn = 1'b0;

   alu_out_t    expected_words[$];
   int          errors = 0;
   int          cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   vector_t     directed[$];

   always #6 clock = ~clock;

   programmer_calculator_alu i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // predicted ALU output for one word at the current settings
   function automatic alu_out_t alu_predict(input logic [3:0] op, input logic [31:0] a,
                                            input logic [31:0] b);
      alu_out_t    r;
      int          w;
      logic [63:0] m, res, v;
      longint      sa, sb, q;
      int          amt;
      logic        na, nb, nr;
      w = (cur_wsel == WS_8) ? 8 : (cur_wsel == WS_16) ? 16 : 32;
      m = (64'd1 << w) - 1;
      res = '0;
      r.ovf = 1'b0;
      r.derr = 1'b0;
      na = a[w-1];
      nb = b[w-1];
      case (op)
         OP_PASS: res = {32'd0, a};
         OP_AND:  res = {32'd0, a & b};
         OP_OR:   res = {32'd0, a | b};
         OP_XOR:  res = {32'd0, a ^ b};
         OP_NOT:  res = {32'd0, ~a};
         OP_SHL:  res = (b >= 32) ? 64'd0 : ({32'd0, a << b[4:0]} & m);
         OP_SHR:  res = (b >= 32) ? 64'd0 : ({32'd0, a >> b[4:0]} & m);
         OP_ROTL, OP_ROTR: begin
            v = {32'd0, a} & m;
            amt = b % w;
            if (amt == 0) res = v;
            else if (op == OP_ROTL) res = ((v << amt) | (v >> (w - amt))) & m;
            else res = ((v >> amt) | (v << (w - amt))) & m;
         end
         OP_MOD, OP_DIV: begin
            if (cur_sgn) begin
               sa = longint'({32'd0, a} & m);
               sb = longint'({32'd0, b} & m);
               if (a[w-1]) sa = sa - (longint'(1) << w);
               if (b[w-1]) sb = sb - (longint'(1) << w);
               if (sb == 0) r.derr = 1'b1;
               else begin
                  q = (op == OP_MOD) ? sa % sb : sa / sb;
                  res = 64'(q) & m;
                  if (res[w-1]) res = res | ~m;
               end
            end else if (b == 0) r.derr = 1'b1;
            else res = (op == OP_MOD) ? {32'd0, a % b} : {32'd0, a / b};
         end
         OP_MUL:  res = {32'd0, a} * {32'd0, b};
         OP_SUB: begin
            res = {32'd0, a} - {32'd0, b};
            nr = res[w-1];
            r.ovf = (!na && nb && nr) || (na && !nb && !nr);
         end
         OP_ADD: begin
            res = {32'd0, a} + {32'd0, b};
            nr = res[w-1];
            r.ovf = (na && nb && !nr) || (!na && !nb && nr);
         end
         default: res = '0;
      endcase
      if (r.derr) begin
         r.value = '0;
         r.carry = 1'b0;
         r.ovf = 1'b0;
      end else begin
         r.value = res[31:0];
         r.carry = (res >> w) != 0;
      end
      return r;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random stall and compare against oldest expectation
   always @(posedge clock) begin
      alu_out_t e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word %h", $time, rsp_tdata);
               errors++;
            end else begin
               e = expected_words.pop_front();
               if (rsp_tdata[31:0] !== e.value || rsp_tdata[32] !== e.carry ||
                   rsp_tdata[33] !== e.ovf || rsp_tdata[34] !== e.derr) begin
                  $display("%0t: mismatch expected v=%h c=%b o=%b d=%b actual v=%h c=%b o=%b d=%b",
                           $time, e.value, e.carry, e.ovf, e.derr, rsp_tdata[31:0],
                           rsp_tdata[32], rsp_tdata[33], rsp_tdata[34]);
                  errors++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic csr_write(input logic idx, input logic [1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_WORD_SIZE) cur_wsel = val;
      else cur_sgn = val[0];
   endtask

   // send one word; expectation is queued as it is accepted; valid stays up
   // for a following word and is dropped only while idling, draining or holding off
   task automatic send_word(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b,
                            input logic check_known, input alu_out_t typed);
      alu_out_t p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      p = alu_predict(op, a, b);
      if (check_known) p = typed;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {b, a};
      do @(posedge clock); while (!req_tready);
      expected_words.push_back(p);
   endtask

   task automatic drain();
      int n;
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      for (n = 0; n < LATENCY + 5; n++) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(5))
         0: return $urandom_range(255);
         1: return 32'hFFFF_FFFF - $urandom_range(3);
         2: return 32'h8000_0000 >> $urandom_range(24);
         3: return 32'(1 << $urandom_range(31)) - 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic vector_t vec(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b,
                                   input logic k, input logic [31:0] v, input logic c,
                                   input logic o, input logic d);
      vector_t t;
      t.op = op; t.a = a; t.b = b; t.known = k;
      t.value = v; t.carry = c; t.ovf = o; t.derr = d;
      return t;
   endfunction

   initial begin
      alu_out_t typed, dummy;
      logic [31:0] a, b;
      logic [3:0]  op;
      int i, phase, n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at reset settings (32 bits, unsigned)
      directed.push_back(vec(OP_PASS, 32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF, 0, 0, 0));
      directed.push_back(vec(OP_AND, 32'hF0F0_F0F0, 32'hFF00_FF00, 1, 32'hF000_F000, 0, 0, 0));
      directed.push_back(vec(OP_OR, 32'h0F0F_0000, 32'h0000_F0F0, 1, 32'h0F0F_F0F0, 0, 0, 0));
      directed.push_back(vec(OP_XOR, 32'hFFFF_FFFF, 32'h5555_5555, 1, 32'hAAAA_AAAA, 0, 0, 0));
      directed.push_back(vec(OP_NOT, 32'h0, 0, 1, 32'hFFFF_FFFF, 0, 0, 0));
      directed.push_back(vec(OP_SHL, 32'h1, 31, 1, 32'h8000_0000, 0, 0, 0));
      directed.push_back(vec(OP_SHL, 32'hFFFF_FFFF, 32, 1, 0, 0, 0, 0));
      directed.push_back(vec(OP_SHR, 32'h8000_0000, 32'hFFFF_FFFF, 1, 0, 0, 0, 0));
      directed.push_back(vec(OP_ROTL, 32'h8000_0001, 33, 1, 32'h0000_0003, 0, 0, 0));
      directed.push_back(vec(OP_ROTR, 32'h8000_0001, 0, 1, 32'h8000_0001, 0, 0, 0));
      directed.push_back(vec(OP_MOD, 32'd7, 0, 1, 0, 0, 0, 1));
      directed.push_back(vec(OP_DIV, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 1));
      directed.push_back(vec(OP_DIV, 32'hFFFF_FFFF, 32'd1, 1, 32'hFFFF_FFFF, 0, 0, 0));
      directed.push_back(vec(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h1, 1, 0, 0));
      directed.push_back(vec(OP_SUB, 32'h8000_0000, 32'h1, 1, 32'h7FFF_FFFF, 0, 1, 0));
      directed.push_back(vec(OP_SUB, 32'h0, 32'h1, 1, 32'hFFFF_FFFF, 1, 0, 0));
      directed.push_back(vec(OP_ADD, 32'h7FFF_FFFF, 32'h1, 1, 32'h8000_0000, 0, 1, 0));
      directed.push_back(vec(OP_ADD, 32'hFFFF_FFFF, 32'h1, 1, 0, 1, 0, 0));
      directed.push_back(vec(4'd14, 32'h1234_5678, 32'h1, 1, 0, 0, 0, 0));
      directed.push_back(vec(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 0, 0));
      foreach (directed[k]) begin
         typed.value = directed[k].value; typed.carry = directed[k].carry;
         typed.ovf = directed[k].ovf; typed.derr = directed[k].derr;
         send_word(directed[k].op, directed[k].a, directed[k].b, directed[k].known, typed);
      end
      drain();

      // signed special cases at 8 bits: minimum by minus one, negative remainder
      csr_write(REG_WORD_SIZE, WS_8);
      csr_write(REG_SIGNED_MODE, 1'b1);
      send_word(OP_DIV, 32'h80, 32'hFF, 0, dummy);
      send_word(OP_MOD, 32'h80, 32'hFF, 0, dummy);
      send_word(OP_DIV, 32'hF9, 32'h02, 0, dummy);
      send_word(OP_MOD, 32'hF9, 32'h02, 0, dummy);
      send_word(OP_DIV, 32'h1234_5601, 32'hFFFF_FF00, 0, dummy);
      send_word(OP_NOT, 32'h0, 0, 0, dummy);
      drain();

      // random phases over settings and idle profiles
      for (phase = 0; phase < 12; phase++) begin
         csr_write(REG_WORD_SIZE, (phase % 4 == 3) ? 2'd3 : 2'(phase % 4));
         csr_write(REG_SIGNED_MODE, phase[2]);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         n = 112;
         for (i = 0; i < n; i++) begin
            op = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(13));
            a = rand_operand();
            b = rand_operand();
            if (op == OP_SHL || op == OP_SHR || op == OP_ROTL || op == OP_ROTR) begin
               if ($urandom_range(3) != 0) b = $urandom_range(40);
            end else if ((op == OP_DIV || op == OP_MOD) && $urandom_range(9) == 0) begin
               b = $urandom_range(1) ? 32'd0 : ($urandom << 8);
            end
            send_word(op, a, b, 0, dummy);
            // sender holds off until the pipeline is empty
            if (i == n / 2 && phase == 5) begin
               req_tvalid <= 1'b0;
               while (expected_words.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/pcalu_pkg.sv
rtl/programmer_calculator_alu.sv
test/tb_programmer_calculator_alu.sv
